>>> rtl/core/bafp_pkg.sv
// Shared widths, field type codes and parser phase type for the advertising field parser.
package bafp_pkg;

    localparam int DATA_W     = 8;
    localparam int TOTAL_W    = 6;
    localparam int UUID_W     = 16;
    localparam int NAME_LEN_W = 5;
    localparam int FIELD_W    = 6;

    localparam logic [DATA_W-1:0] AD_UUID16_PART  = 8'h02;
    localparam logic [DATA_W-1:0] AD_UUID16_FULL  = 8'h03;
    localparam logic [DATA_W-1:0] AD_NAME_SHORT   = 8'h08;
    localparam logic [DATA_W-1:0] AD_NAME_FULL    = 8'h09;

    localparam logic [UUID_W-1:0]     UUID_RESET   = 16'hA032;
    localparam logic [NAME_LEN_W-1:0] NAME_LEN_SAT = 5'd31;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

endpackage

>>> rtl/core/bafp_in_if.sv
// Input byte channel: valid/ready with one buffer byte and its framing.
interface bafp_in_if
    import bafp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  data_byte;
    logic [TOTAL_W-1:0] total_length;
    logic               last;

    modport source (output valid, output data_byte, output total_length, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input total_length, input last,
                    output ready);
endinterface

>>> rtl/core/bafp_out_if.sv
// Result channel: valid/ready with name character and end-of-buffer report.
interface bafp_out_if
    import bafp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  name_valid;
    logic [DATA_W-1:0]     name_char;
    logic                  name_start;
    logic                  done_res;
    logic                  service_seen;
    logic [NAME_LEN_W-1:0] name_length;

    modport source (output valid, output name_valid, output name_char, output name_start,
                    output done_res, output service_seen, output name_length,
                    input ready);
    modport sink   (input valid, input name_valid, input name_char, input name_start,
                    input done_res, input service_seen, input name_length,
                    output ready);
endinterface

>>> rtl/core/bafp_cfg_if.sv
// Configuration write channel: valid/ready with the service UUID value.
interface bafp_cfg_if
    import bafp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [UUID_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ble_adv_field_parser.sv
// Top level: streaming BLE advertising data structure parser with name and UUID extraction.
//
//  channel  | dir | transfer when          | carries
//  ---------+-----+------------------------+------------------------------------------
//  i_in     | in  | valid && ready         | data_byte, total_length, last
//  o_out    | out | valid && ready         | name_valid/char/start, done_res, seen, length
//  i_cfg    | in  | valid && ready         | service UUID (always ready)
//
//  One byte per cycle: the parse state update is one step of logic feeding the
//  output register, so a byte is accepted every cycle while the result is taken.
//  The result is registered and becomes valid in the cycle after the input transfer.
//  Reset (synchronous, active low) clears the parse state and loads UUID 0xA032.
//  A stalled result holds the output register and drops i_in.ready until taken.
module ble_adv_field_parser
    import bafp_pkg::*;
#(
    parameter int NAME_MAX   = 31,
    parameter int BUFFER_MAX = 62
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bafp_in_if.sink      i_in,
    bafp_out_if.source   o_out,
    bafp_cfg_if.sink     i_cfg
);

    localparam int PW  = $clog2(BUFFER_MAX + 1);
    localparam int NW  = $clog2(NAME_MAX + 1);
    localparam int SW  = ((PW > DATA_W) ? PW : DATA_W) + 2;
    localparam int NCW = (NW > NAME_LEN_W) ? NW : NAME_LEN_W;

    logic [UUID_W-1:0]  r_uuid;
    logic [PW-1:0]      r_pos,       n_pos;
    t_phase             r_phase,     n_phase;
    logic [FIELD_W-1:0] r_left,      n_left;
    logic [DATA_W-1:0]  r_kind,      n_kind;
    logic [DATA_W-1:0]  r_uuid_lo,   n_uuid_lo;
    logic               r_half,      n_half;
    logic               r_match,     n_match;
    logic [NW-1:0]      r_name_cnt,  n_name_cnt;

    logic                  r_out_valid;
    logic                  r_nvalid;
    logic [DATA_W-1:0]     r_nchar;
    logic                  r_nstart;
    logic                  r_done;
    logic                  r_seen;
    logic [NAME_LEN_W-1:0] r_nlen;

    logic                  c_nvalid;
    logic [DATA_W-1:0]     c_nchar;
    logic                  c_nstart;
    logic [NAME_LEN_W-1:0] c_nlen;
    logic [SW-1:0]         c_pos1;
    logic [SW-1:0]         c_total;
    logic [SW-1:0]         c_byte;
    logic [NCW-1:0]        c_cnt_ext;
    logic                  c_is_name;
    logic                  c_is_uuid;
    logic                  in_xfer;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_left     = r_left;
        n_kind     = r_kind;
        n_uuid_lo  = r_uuid_lo;
        n_half     = r_half;
        n_match    = r_match;
        n_name_cnt = r_name_cnt;
        c_nvalid   = 1'b0;
        c_nchar    = '0;
        c_nstart   = 1'b0;
        c_pos1     = SW'(r_pos) + SW'(1);
        c_total    = SW'(i_in.total_length);
        c_byte     = SW'(i_in.data_byte);
        c_is_name  = (r_kind == AD_NAME_SHORT) || (r_kind == AD_NAME_FULL);
        c_is_uuid  = (r_kind == AD_UUID16_PART) || (r_kind == AD_UUID16_FULL);

        case (r_phase)
            PH_LEN: begin
                if ((c_pos1 >= c_total) || (i_in.data_byte == '0) ||
                    ((c_pos1 + c_byte) > c_total)) begin
                    n_phase = PH_STOP;
                end else begin
                    n_left  = i_in.data_byte[FIELD_W-1:0] - FIELD_W'(1);
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_kind = i_in.data_byte;
                n_half = 1'b0;
                if (r_left == '0) begin
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_DATA;
                    if ((i_in.data_byte == AD_NAME_SHORT) ||
                        (i_in.data_byte == AD_NAME_FULL)) begin
                        n_name_cnt = '0;
                    end
                end
            end
            PH_DATA: begin
                if (c_is_name) begin
                    if (r_name_cnt < NW'(NAME_MAX)) begin
                        c_nvalid   = 1'b1;
                        c_nchar    = i_in.data_byte;
                        c_nstart   = (r_name_cnt == '0);
                        n_name_cnt = r_name_cnt + NW'(1);
                    end
                end else if (c_is_uuid) begin
                    if (!r_half) begin
                        n_uuid_lo = i_in.data_byte;
                        n_half    = 1'b1;
                    end else begin
                        if ({i_in.data_byte, r_uuid_lo} == r_uuid) begin
                            n_match = 1'b1;
                        end
                        n_half = 1'b0;
                    end
                end
                n_left = r_left - FIELD_W'(1);
                if (n_left == '0) begin
                    n_phase = PH_LEN;
                end
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        if (r_pos < PW'(BUFFER_MAX)) begin
            n_pos = r_pos + PW'(1);
        end

        c_cnt_ext = NCW'(n_name_cnt);
        c_nlen    = (c_cnt_ext > NCW'(NAME_LEN_SAT)) ? NAME_LEN_SAT
                                                      : c_cnt_ext[NAME_LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uuid     <= UUID_RESET;
            r_pos      <= '0;
            r_phase    <= PH_LEN;
            r_left     <= '0;
            r_kind     <= '0;
            r_uuid_lo  <= '0;
            r_half     <= 1'b0;
            r_match    <= 1'b0;
            r_name_cnt <= '0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_uuid <= i_cfg.data;
            end
            if (in_xfer) begin
                if (i_in.last) begin
                    r_pos      <= '0;
                    r_phase    <= PH_LEN;
                    r_left     <= '0;
                    r_kind     <= '0;
                    r_uuid_lo  <= '0;
                    r_half     <= 1'b0;
                    r_match    <= 1'b0;
                    r_name_cnt <= '0;
                end else begin
                    r_pos      <= n_pos;
                    r_phase    <= n_phase;
                    r_left     <= n_left;
                    r_kind     <= n_kind;
                    r_uuid_lo  <= n_uuid_lo;
                    r_half     <= n_half;
                    r_match    <= n_match;
                    r_name_cnt <= n_name_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_nvalid <= c_nvalid;
            r_nchar  <= c_nchar;
            r_nstart <= c_nstart;
            r_done   <= i_in.last;
            r_seen   <= i_in.last ? n_match : 1'b0;
            r_nlen   <= i_in.last ? c_nlen : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.name_valid   = r_nvalid;
    assign o_out.name_char    = r_nchar;
    assign o_out.name_start   = r_nstart;
    assign o_out.done_res     = r_done;
    assign o_out.service_seen = r_seen;
    assign o_out.name_length  = r_nlen;

    a_start_is_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_nstart) |-> r_nvalid)
        else $error("name_start without name character");

    a_report_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |-> (!r_seen && (r_nlen == '0)))
        else $error("end report outside last byte");

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted byte produced no result");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.last) |=> ((r_pos == '0) && (r_phase == PH_LEN) && !r_match))
        else $error("parser did not restart after last byte");

endmodule

>>> bench/testbench.sv
// Self-checking bench for the advertising field parser: paced byte driver, result monitor, predictor.
`timescale 1ns / 1ps

module testbench;
    import bafp_pkg::*;

    localparam int NAME_LIMIT = 31;
    localparam int BUF_LIMIT  = 62;
    localparam int CYCLE_CAP  = 400000;
    localparam int PER_SETTING = 290;

    localparam logic [DATA_W-1:0] AD_FLAGS  = 8'h01;
    localparam logic [DATA_W-1:0] AD_VENDOR = 8'hFF;

    typedef struct {
        logic [DATA_W-1:0]  data_byte;
        logic [TOTAL_W-1:0] total_length;
        logic               last;
    } t_adv_byte;

    typedef struct packed {
        logic                  name_valid;
        logic [DATA_W-1:0]     name_char;
        logic                  name_start;
        logic                  done_res;
        logic                  service_seen;
        logic [NAME_LEN_W-1:0] name_length;
    } t_parse_result;

    typedef struct {
        t_phase            phase;
        logic [5:0]        position;
        logic [FIELD_W-1:0] field_left;
        logic [DATA_W-1:0] kind;
        logic [DATA_W-1:0] uuid_lo;
        logic              uuid_half;
        logic              seen;
        logic [4:0]        name_count;
    } t_parse_state;

    logic i_clk;
    logic i_rst_n;

    bafp_in_if  in_if();
    bafp_out_if out_if();
    bafp_cfg_if cfg_if();

    ble_adv_field_parser #(
        .NAME_MAX   (NAME_LIMIT),
        .BUFFER_MAX (BUF_LIMIT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_adv_byte     pending_q[$];
    t_parse_result expected_q[$];
    logic [DATA_W-1:0] frame_q[$];

    t_parse_state  parse_st;
    logic [UUID_W-1:0] target_uuid;

    int cycles;
    int errors;
    int n_checked;
    int n_names;
    int n_done;
    int n_hits;
    int n_queued;
    int n_uuid_writes;
    int burst_left = 1;
    int gap_left = 0;
    int pace_left = 0;
    int pace_mode;
    logic [15:0] pace_bits;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
    end

    initial begin : watchdog
        wait (cycles >= CYCLE_CAP);
        $display("** ble_adv_field_parser: FAILED **");
        $finish;
    end

    function automatic void clear_parse();
        parse_st.phase      = PH_LEN;
        parse_st.position   = '0;
        parse_st.field_left = '0;
        parse_st.kind       = '0;
        parse_st.uuid_lo    = '0;
        parse_st.uuid_half  = 1'b0;
        parse_st.seen       = 1'b0;
        parse_st.name_count = '0;
    endfunction

    function automatic t_parse_result parse_byte(input logic [DATA_W-1:0] b,
                                                 input logic [TOTAL_W-1:0] total,
                                                 input logic last);
        t_parse_result r;
        logic is_name;
        logic is_uuid;
        r = '0;
        is_name = (parse_st.kind == AD_NAME_SHORT) || (parse_st.kind == AD_NAME_FULL);
        is_uuid = (parse_st.kind == AD_UUID16_PART) || (parse_st.kind == AD_UUID16_FULL);
        case (parse_st.phase)
            PH_LEN: begin
                if (int'(parse_st.position) + 1 >= int'(total) || b == 8'd0 ||
                    int'(parse_st.position) + 1 + int'(b) > int'(total)) begin
                    parse_st.phase = PH_STOP;
                end else begin
                    parse_st.field_left = FIELD_W'(b - 8'd1);
                    parse_st.phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                parse_st.kind = b;
                parse_st.uuid_half = 1'b0;
                if (parse_st.field_left == 0) begin
                    parse_st.phase = PH_LEN;
                end else begin
                    parse_st.phase = PH_DATA;
                    if (b == AD_NAME_SHORT || b == AD_NAME_FULL)
                        parse_st.name_count = '0;
                end
            end
            PH_DATA: begin
                if (is_name) begin
                    if (int'(parse_st.name_count) < NAME_LIMIT) begin
                        r.name_valid = 1'b1;
                        r.name_char  = b;
                        r.name_start = (parse_st.name_count == 0);
                        parse_st.name_count = parse_st.name_count + 5'd1;
                    end
                end else if (is_uuid) begin
                    if (!parse_st.uuid_half) begin
                        parse_st.uuid_lo = b;
                        parse_st.uuid_half = 1'b1;
                    end else begin
                        if ({b, parse_st.uuid_lo} == target_uuid)
                            parse_st.seen = 1'b1;
                        parse_st.uuid_half = 1'b0;
                    end
                end
                parse_st.field_left = parse_st.field_left - 1'b1;
                if (parse_st.field_left == 0)
                    parse_st.phase = PH_LEN;
            end
            default: ;
        endcase
        if (int'(parse_st.position) < BUF_LIMIT)
            parse_st.position = parse_st.position + 6'd1;
        r.done_res = last;
        if (last) begin
            r.service_seen = parse_st.seen;
            r.name_length  = parse_st.name_count;
            clear_parse();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.data_byte    <= '0;
            in_if.total_length <= '0;
            in_if.last         <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                pending_q.delete(0);
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    in_if.valid        <= 1'b1;
                    in_if.data_byte    <= pending_q[0].data_byte;
                    in_if.total_length <= pending_q[0].total_length;
                    in_if.last         <= pending_q[0].last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_pacer
        logic rdy;
        if (pace_left <= 0) begin
            pace_mode = $urandom_range(0, 3);
            pace_bits = 16'($urandom) | 16'h0001;
            pace_left = $urandom_range(20, 120);
        end
        pace_left--;
        case (pace_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 3) != 0);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = pace_bits[pace_left % 16];
        endcase
        out_if.ready <= rdy;
    end

    always @(posedge i_clk) begin : result_monitor
        t_parse_result got;
        t_parse_result want;
        if (!i_rst_n) begin
            clear_parse();
            target_uuid = UUID_RESET;
        end else begin
            if (cfg_if.valid && cfg_if.ready)
                target_uuid = cfg_if.data;
            if (in_if.valid && in_if.ready)
                expected_q.push_back(parse_byte(in_if.data_byte, in_if.total_length,
                                                in_if.last));
            if (out_if.valid && out_if.ready) begin
                got = {out_if.name_valid, out_if.name_char, out_if.name_start,
                       out_if.done_res, out_if.service_seen, out_if.name_length};
                n_checked++;
                if (expected_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d with nothing expected: %h", n_checked, got);
                end else begin
                    want = expected_q.pop_front();
                    n_names += want.name_valid;
                    if (want.done_res) begin
                        n_done++;
                        n_hits += want.service_seen;
                    end
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result %0d mismatch: exp nv=%b ch=%h st=%b dn=%b ",
                                      "seen=%b len=%0d / got nv=%b ch=%h st=%b dn=%b ",
                                      "seen=%b len=%0d"}, n_checked,
                                     want.name_valid, want.name_char, want.name_start,
                                     want.done_res, want.service_seen, want.name_length,
                                     got.name_valid, got.name_char, got.name_start,
                                     got.done_res, got.service_seen, got.name_length);
                    end
                end
            end
        end
    end

    task automatic flush_frame(input int total);
        int i;
        for (i = 0; i < frame_q.size(); i++)
            pending_q.push_back('{frame_q[i], TOTAL_W'(total), i == frame_q.size() - 1});
        n_queued += frame_q.size();
        frame_q.delete();
    endtask

    task automatic add_random_buffer(input logic [UUID_W-1:0] uuid_now);
        int total;
        int left;
        int flen;
        int i;
        logic [DATA_W-1:0] kind;
        logic [UUID_W-1:0] id;
        if ($urandom_range(0, 9) < 8) begin
            total = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 12) : $urandom_range(13, 62);
            left = total;
            while (left > 0) begin
                if (left == 1 || $urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 2))
                        0: frame_q.push_back(8'd0);
                        1: frame_q.push_back(8'(left + $urandom_range(0, 3)));
                        default: frame_q.push_back(8'($urandom));
                    endcase
                    while (frame_q.size() < total)
                        frame_q.push_back(8'($urandom));
                    left = 0;
                end else begin
                    flen = ($urandom_range(0, 3) == 0) ? left - 1
                         : $urandom_range(1, (left - 1 < 12) ? left - 1 : 12);
                    case ($urandom_range(0, 7))
                        0, 1: kind = AD_NAME_FULL;
                        2: kind = AD_NAME_SHORT;
                        3: kind = AD_UUID16_PART;
                        4: kind = AD_UUID16_FULL;
                        5: kind = AD_FLAGS;
                        6: kind = AD_VENDOR;
                        default: kind = 8'($urandom);
                    endcase
                    frame_q.push_back(8'(flen));
                    frame_q.push_back(kind);
                    id = '0;
                    for (i = 0; i < flen - 1; i++) begin
                        if (kind == AD_UUID16_PART || kind == AD_UUID16_FULL) begin
                            if (i % 2 == 0) begin
                                case ($urandom_range(0, 5))
                                    0, 1: id = uuid_now;
                                    2: id = uuid_now ^ (16'h1 << $urandom_range(0, 15));
                                    default: id = 16'($urandom);
                                endcase
                                frame_q.push_back(id[7:0]);
                            end else begin
                                frame_q.push_back(id[15:8]);
                            end
                        end else begin
                            frame_q.push_back(8'($urandom));
                        end
                    end
                    left -= flen + 1;
                end
            end
        end else begin
            total = $urandom_range(0, 63);
            left = $urandom_range(1, 70);
            for (i = 0; i < left; i++)
                frame_q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 8))
                                                              : 8'($urandom));
        end
        flush_frame(total);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending_q.size() != 0 || expected_q.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_uuid(input logic [UUID_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        n_uuid_writes++;
    endtask

    initial begin : stimulus
        logic [UUID_W-1:0] settings[5];
        int s;
        int goal;
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // name then matching UUID at the reset value
        frame_q = '{8'd3, AD_NAME_FULL, 8'h41, 8'h42, 8'd3, AD_UUID16_FULL, 8'h32, 8'hA0};
        flush_frame(8);
        // zero length stops the walk
        frame_q = '{8'd0, 8'hFF, 8'h80};
        flush_frame(3);
        // field overruns the buffer
        frame_q = '{8'd5, AD_NAME_SHORT, 8'h61, 8'h62};
        flush_frame(4);
        // empty name field keeps the earlier name; odd UUID byte dropped
        frame_q = '{8'd2, AD_NAME_FULL, 8'h5A, 8'd1, AD_NAME_SHORT,
                    8'd4, AD_UUID16_PART, 8'h32, 8'hA0, 8'h77};
        flush_frame(10);
        // lone final byte is not a header
        frame_q = '{8'd1, AD_VENDOR, 8'd2};
        flush_frame(3);

        settings[0] = UUID_RESET;
        settings[1] = 16'h0000;
        settings[2] = 16'hFFFF;
        settings[3] = 16'($urandom);
        settings[4] = 16'($urandom);
        for (s = 0; s < 5; s++) begin
            if (s != 0) begin
                wait_drained();
                write_uuid(settings[s]);
            end
            goal = n_queued + PER_SETTING;
            while (n_queued < goal)
                add_random_buffer(settings[s]);
        end

        wait_drained();
        if (expected_q.size() != 0)
            errors++;
        $display("%0d bytes checked over %0d buffers, %0d name chars, %0d UUID hits",
                 n_checked, n_done, n_names, n_hits);
        $display("%0d UUID writes incl. 0x0000 and 0xFFFF, %0d mismatches",
                 n_uuid_writes, errors);
        if (errors == 0) begin
            $display("** ble_adv_field_parser: PASSED **");
        end else begin
            $display("** ble_adv_field_parser: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/bafp_pkg.sv
rtl/core/bafp_in_if.sv
rtl/core/bafp_out_if.sv
rtl/core/bafp_cfg_if.sv
rtl/core/ble_adv_field_parser.sv
bench/testbench.sv
